>>> src/rhcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhcs_pkg
// Shared types and constants for the ramp/hold/cool setpoint generator.
// ----------------------------------------------------------------------------
package rhcs_pkg;

  localparam int CYC_W     = 18;
  localparam int DUR_W     = 16;
  localparam int TEMP_W    = 13;
  localparam int PH_W      = 2;
  localparam int PROD_W    = DUR_W + TEMP_W;
  localparam int DIV_CNT_W = 4;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  localparam logic [DUR_W-1:0]  RAMP_RST = 16'd60;
  localparam logic [DUR_W-1:0]  HOLD_RST = 16'd10;
  localparam logic [DUR_W-1:0]  COOL_RST = 16'd60;
  localparam logic [TEMP_W-1:0] LOW_RST  = 13'd0;
  localparam logic [TEMP_W-1:0] HIGH_RST = 13'd800;
  localparam logic [TEMP_W-1:0] SP_MAX   = 13'd8191;

  typedef enum logic [2:0] {
    REG_RAMP,
    REG_HOLD,
    REG_COOL,
    REG_LOW,
    REG_HIGH
  } reg_idx_t;

  typedef enum logic [PH_W-1:0] {
    PH_RAMP,
    PH_HOLD,
    PH_COOL
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASS,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic adv;
    logic classify;
    logic mul;
    logic div_step;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_busy;
  } dp_sts_t;

  typedef struct packed {
    logic [DUR_W-1:0]  ramp;
    logic [DUR_W-1:0]  hold;
    logic [DUR_W-1:0]  cool;
    logic [TEMP_W-1:0] low;
    logic [TEMP_W-1:0] high;
  } cfg_t;

endpackage

>>> src/rhcs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhcs_if
// Valid/ready channels for tick requests and setpoint results.
// ----------------------------------------------------------------------------
interface rhcs_in_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

interface rhcs_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] setpoint;
  logic [1:0]  phase;

  modport source (output valid, output setpoint, output phase, input ready);
  modport sink (input valid, input setpoint, input phase, output ready);
endinterface

>>> src/rhcs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhcs_ctrl
// Sequencer: advance, classify, multiply, divide, then load the result.
// ----------------------------------------------------------------------------
module rhcs_ctrl
  import rhcs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.adv   = 1'b1;
          state_nxt = ST_CLASS;
        end
      end
      ST_CLASS: begin
        cmd.classify = 1'b1;
        state_nxt    = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/rhcs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhcs_dp
// Cycle position, phase decode, offset multiply, serial divide, output reg.
// ----------------------------------------------------------------------------
module rhcs_dp
  import rhcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  input  cfg_t              cfg,
  input  logic              in_tick,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [TEMP_W-1:0] out_setpoint,
  output logic [PH_W-1:0]   out_phase
);

  logic [CYC_W-1:0]     cycle_r;
  phase_t               phase_r;
  logic                 zero_r;
  logic [DUR_W-1:0]     t_r;
  logic [DUR_W-1:0]     len_r;
  logic [TEMP_W-1:0]    d_r;
  logic [DUR_W-1:0]     rem_r;
  logic [TEMP_W-1:0]    quo_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [TEMP_W-1:0]    setpoint_r;
  logic [PH_W-1:0]      out_phase_r;
  logic                 out_valid_r;

  logic [CYC_W-1:0]  total;
  logic [CYC_W-1:0]  rh_sum;
  logic [CYC_W-1:0]  cyc_base;
  logic [CYC_W-1:0]  cyc_inc;
  logic [CYC_W-1:0]  cyc_adv;
  logic [CYC_W-1:0]  cool_pos;
  logic [TEMP_W-1:0] d_abs;
  logic [PROD_W-1:0] prod;
  logic [DUR_W:0]    shifted;
  logic [DUR_W+1:0]  trial;
  logic [TEMP_W:0]   ramp_sum;
  logic [TEMP_W-1:0] sp_val;

  assign total    = {2'b00, cfg.ramp} + {2'b00, cfg.hold} + {2'b00, cfg.cool};
  assign rh_sum   = {2'b00, cfg.ramp} + {2'b00, cfg.hold};
  assign cyc_base = (cycle_r >= total) ? '0 : cycle_r;
  assign cyc_inc  = cyc_base + CYC_W'(in_tick);
  assign cyc_adv  = (cyc_inc >= total) ? '0 : cyc_inc;
  assign cool_pos = cycle_r - rh_sum;
  assign d_abs    = (cfg.high >= cfg.low) ? (cfg.high - cfg.low) : (cfg.low - cfg.high);

  assign prod     = PROD_W'(t_r) * PROD_W'(d_r);
  assign shifted  = {rem_r, quo_r[TEMP_W-1]};
  assign trial    = {1'b0, shifted} - {2'b00, len_r};
  assign ramp_sum = {1'b0, cfg.low} + {1'b0, quo_r};

  always_comb begin
    if (zero_r) begin
      sp_val = cfg.low;
    end else begin
      case (phase_r)
        PH_RAMP: sp_val = ramp_sum[TEMP_W] ? SP_MAX : ramp_sum[TEMP_W-1:0];
        PH_HOLD: sp_val = cfg.high;
        PH_COOL: sp_val = (quo_r >= cfg.high) ? '0 : (cfg.high - quo_r);
        default: sp_val = cfg.high;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.adv) begin
        cycle_r <= cyc_adv;
      end
      if (cmd.mul) begin
        cnt_r <= '0;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.classify) begin
      d_r <= d_abs;
      if (total == '0) begin
        zero_r  <= 1'b1;
        phase_r <= PH_RAMP;
        t_r     <= '0;
        len_r   <= cfg.ramp;
      end else if (cycle_r < {2'b00, cfg.ramp}) begin
        zero_r  <= 1'b0;
        phase_r <= PH_RAMP;
        t_r     <= cycle_r[DUR_W-1:0];
        len_r   <= cfg.ramp;
      end else if (cycle_r < rh_sum) begin
        zero_r  <= 1'b0;
        phase_r <= PH_HOLD;
        t_r     <= '0;
        len_r   <= cfg.hold;
      end else begin
        zero_r  <= 1'b0;
        phase_r <= PH_COOL;
        t_r     <= cool_pos[DUR_W-1:0];
        len_r   <= cfg.cool;
      end
    end
    // t < len, so the upper product bits are already below the divisor
    if (cmd.mul) begin
      rem_r <= prod[PROD_W-1:TEMP_W];
      quo_r <= prod[TEMP_W-1:0];
    end else if (cmd.div_step) begin
      rem_r <= trial[DUR_W+1] ? shifted[DUR_W-1:0] : trial[DUR_W-1:0];
      quo_r <= {quo_r[TEMP_W-2:0], ~trial[DUR_W+1]};
    end
    if (cmd.load) begin
      setpoint_r  <= sp_val;
      out_phase_r <= phase_r;
    end
  end

  assign sts.div_last  = (cnt_r == DIV_CNT_W'(TEMP_W - 1));
  assign sts.out_busy  = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_setpoint  = setpoint_r;
  assign out_phase     = out_phase_r;

endmodule

>>> src/ramp_hold_cool_setpoint_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ramp_hold_cool_setpoint_top
// Ramp/hold/cool temperature setpoint generator with APB register port.
// ----------------------------------------------------------------------------
// Each request on in_ch (tick = 1 advances one second, tick = 0 recomputes)
// yields one result on out_ch: the setpoint in 1/16 degree units and the
// phase (0 ramp, 1 hold, 2 cool). A request goes through the classify,
// multiply and divide states to a loaded result; a new request is taken
// the cycle after the load. The restoring divider forms one quotient bit per
// cycle. The result register lets the next request start while
// a result waits; a result that is still unread when the next one is ready
// holds the sequencer. Registers at 4*i: ramp, hold, cool seconds, low and
// high temperature; write them only while no request is in flight.
// ----------------------------------------------------------------------------
module ramp_hold_cool_setpoint_top
  import rhcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  rhcs_in_if.sink           in_ch,
  rhcs_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg_r;
  dp_cmd_t  dp_cmd;
  dp_sts_t  dp_sts;
  reg_idx_t reg_idx;
  logic     wr_en;
  logic     ctrl_ready;

  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ramp <= RAMP_RST;
      cfg_r.hold <= HOLD_RST;
      cfg_r.cool <= COOL_RST;
      cfg_r.low  <= LOW_RST;
      cfg_r.high <= HIGH_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RAMP: cfg_r.ramp <= pwdata[DUR_W-1:0];
        REG_HOLD: cfg_r.hold <= pwdata[DUR_W-1:0];
        REG_COOL: cfg_r.cool <= pwdata[DUR_W-1:0];
        REG_LOW:  cfg_r.low  <= pwdata[TEMP_W-1:0];
        REG_HIGH: cfg_r.high <= pwdata[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RAMP: prdata = DATA_W'(cfg_r.ramp);
      REG_HOLD: prdata = DATA_W'(cfg_r.hold);
      REG_COOL: prdata = DATA_W'(cfg_r.cool);
      REG_LOW:  prdata = DATA_W'(cfg_r.low);
      REG_HIGH: prdata = DATA_W'(cfg_r.high);
      default:  prdata = '0;
    endcase
  end

  rhcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ctrl_ready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  assign in_ch.ready = ctrl_ready;

  rhcs_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (dp_cmd),
    .sts          (dp_sts),
    .cfg          (cfg_r),
    .in_tick      (in_ch.tick),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_setpoint (out_ch.setpoint),
    .out_phase    (out_ch.phase)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request accepted while previous one in progress");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.load |-> !dp_sts.out_busy)
    else $error("result loaded over an unread result");

  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(dp_cmd.load))
    else $error("result valid without a load");

endmodule
